// ----- rtl/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, widths and constants of the planar pose integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 25;
   localparam int PROD_W = 64;
   localparam int DEN_W = 35;
   localparam int ANG_W = 34;
   localparam int ATAN_LEN = 24;
   localparam int ITER_CNT_W = 5;

   localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd2147483648;
   localparam logic [DEN_W-1:0] STEP_DIV = 35'd16384000000;
   localparam logic [DEN_W-1:0] US_PER_S = 35'd1000000;
   localparam logic [19:0] MAX_DT_RESET = 20'd1000000;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_SET_VEL = 2'd1,
      OP_SET_POSE = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_SKIP = 2'd1,
      ST_SAT = 2'd2
   } status_type;

   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

   function automatic logic [31:0] atan_entry(input logic [ITER_CNT_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/ppi_mul.sv -----
// ----------------------------------------------------------------------------
// ppi_mul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ppi_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ppi_pkg::MUL_A_W-1:0]    a,
   input  logic signed [ppi_pkg::MUL_B_W-1:0]    b,
   output logic                                  done,
   output logic signed [ppi_pkg::PROD_W-1:0]     p
);
   import ppi_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic              neg_ff, neg_in;
   logic [MUL_A_W-1:0] a_mag;
   logic [MUL_B_W-1:0] b_mag;

   assign a_mag = a[MUL_A_W-1] ? MUL_A_W'(-a) : MUL_A_W'(a);
   assign b_mag = b[MUL_B_W-1] ? MUL_B_W'(-b) : MUL_B_W'(b);
   assign done = busy_ff && (cnt_ff == '0);
   assign p = neg_ff ? signed'(PROD_W'(-acc_ff)) : signed'(acc_ff);

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(MUL_B_W);
         mcand_in = PROD_W'(a_mag);
         mplier_in = b_mag;
         acc_in = '0;
         neg_in = a[MUL_A_W-1] ^ b[MUL_B_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MUL_B_W-1:1]};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
   end

endmodule

// ----- rtl/ppi_div.sv -----
// ----------------------------------------------------------------------------
// ppi_div
// Bit-serial restoring divider that rounds to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module ppi_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [ppi_pkg::PROD_W-1:0]    num,
   input  logic [ppi_pkg::DEN_W-1:0]            den,
   output logic                                 done,
   output logic signed [ppi_pkg::PROD_W-1:0]    q
);
   import ppi_pkg::*;

   localparam int DVD_W = PROD_W + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] mag;
   logic [DEN_W:0]    rem_sh;
   logic              fits;

   assign mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
   assign rem_sh = {rem_ff[DEN_W-1:0], dvd_ff[DVD_W-1]};
   assign fits = rem_sh >= {1'b0, den_ff};
   assign done = busy_ff && (cnt_ff == '0);
   assign q = neg_ff ? signed'(PROD_W'(-dvd_ff[PROD_W-1:0]))
                     : signed'(dvd_ff[PROD_W-1:0]);

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DVD_W);
         dvd_in = DVD_W'(mag) + DVD_W'(den >> 1);
         rem_in = '0;
         den_in = den;
         neg_in = num[PROD_W-1];
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
            dvd_in = {dvd_ff[DVD_W-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

endmodule

// ----- rtl/ppi_cordic.sv -----
// ----------------------------------------------------------------------------
// ppi_cordic
// Iterative rotation-mode CORDIC giving sine and cosine in Q1.30.
// ----------------------------------------------------------------------------
module ppi_cordic #(
   parameter int ITER = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [31:0]                          angle,
   output logic                                 done,
   output logic signed [ppi_pkg::ANG_W-1:0]     sin_out,
   output logic signed [ppi_pkg::ANG_W-1:0]     cos_out
);
   import ppi_pkg::*;

   localparam logic [ITER_CNT_W-1:0] LAST = ITER_CNT_W'(ITER);

   logic                        busy_ff, busy_in;
   logic [ITER_CNT_W-1:0]       cnt_ff, cnt_in;
   logic signed [ANG_W-1:0]     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                        flip_ff, flip_in;
   logic signed [ANG_W-1:0]     z0, atan_v;

   assign z0 = ANG_W'(signed'(angle));
   assign atan_v = signed'(ANG_W'(atan_entry(cnt_ff)));
   assign done = busy_ff && (cnt_ff == LAST);
   assign sin_out = flip_ff ? -y_ff : y_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      flip_in = flip_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         x_in = CORDIC_GAIN;
         y_in = '0;
         if (z0 > QUARTER_TURN) begin
            z_in = z0 - HALF_TURN;
            flip_in = 1'b1;
         end else if (z0 < -QUARTER_TURN) begin
            z_in = z0 + HALF_TURN;
            flip_in = 1'b1;
         end else begin
            z_in = z0;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end else begin
            if (!z_ff[ANG_W-1]) begin
               x_in = x_ff - (y_ff >>> cnt_ff);
               y_in = y_ff + (x_ff >>> cnt_ff);
               z_in = z_ff - atan_v;
            end else begin
               x_in = x_ff + (y_ff >>> cnt_ff);
               y_in = y_ff - (x_ff >>> cnt_ff);
               z_in = z_ff + atan_v;
            end
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
   end

endmodule

// ----- rtl/planar_pose_integrator.sv -----
// Set-velocity and set-pose transactions give no result.  A skipped tick runs
// only the second CORDIC pass before its result; an integrated tick also runs
// the first CORDIC pass and the bit-serial multiplier and divider.  One item is
// worked on at a time.
// Reset clears the pose and the held command to zero and max_dt_us to 1000000.
// ----------------------------------------------------------------------------
// planar_pose_integrator
// Dead reckoning of a holonomic base with a digit-serial datapath.
// ----------------------------------------------------------------------------
module planar_pose_integrator #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // vel_x, vel_y, yaw_rate, dt_us, new_x, new_y, new_heading, zero pad
   input  logic [175:0]  req_tdata,
   // operation
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_x, out_y, out_heading, quat_z, quat_w, out_vel_x, out_vel_y,
   // out_yaw_rate
   output logic [183:0]  rsp_tdata,
   // status
   output logic [1:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   // max_dt_us, zero pad
   input  logic [23:0]   csr_data
);
   import ppi_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_TRIG1 = 8'b00000010,
      S_MUL   = 8'b00000100,
      S_ROUND = 8'b00001000,
      S_DIV   = 8'b00010000,
      S_UPD   = 8'b00100000,
      S_TRIG2 = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic go_ff, go_in;
   logic [19:0] max_dt_ff, max_dt_in, dt_ff, dt_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [15:0] head_ff, head_in, qz_ff, qz_in, qw_ff, qw_in;
   logic signed [23:0] vx_ff, vx_in, vy_ff, vy_in, yaw_ff, yaw_in;
   status_type status_ff, status_in;
   logic signed [ANG_W-1:0] sin_ff, sin_in, cos_ff, cos_in;
   logic signed [PROD_W-1:0] accx_ff, accx_in, accy_ff, accy_in, acch_ff, acch_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [183:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   unit_ctl_type mul_ctl, div_ctl, cor_ctl;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p, div_num, div_q;
   logic [DEN_W-1:0] div_den;
   logic [31:0] cor_angle;
   logic signed [ANG_W-1:0] cor_sin, cor_cos;
   logic req_fire;
   op_type req_op;
   logic [19:0] req_dt;
   logic signed [33:0] sum_x, sum_y;
   logic sat_x, sat_y;

   function automatic logic signed [PROD_W-1:0] round16(
      input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] m;
      logic [PROD_W-1:0] r;
      m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      r = (m + PROD_W'(32768)) >> 16;
      return v[PROD_W-1] ? signed'(PROD_W'(-r)) : signed'(r);
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [ANG_W-1:0] v);
      logic [ANG_W-1:0] m;
      logic [ANG_W-1:0] r;
      logic signed [ANG_W-1:0] s;
      m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
      r = (m + ANG_W'(16384)) >> 15;
      s = v[ANG_W-1] ? signed'(ANG_W'(-r)) : signed'(r);
      if (s > 34'sd32767) begin
         return 16'sh7fff;
      end else if (s < -34'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign req_op = op_type'(req_tuser);
   assign req_dt = req_tdata[91:72];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   assign mul_ctl.start = go_ff && (state_ff == S_MUL);
   assign div_ctl.start = go_ff && (state_ff == S_DIV);
   assign cor_ctl.start = go_ff && (state_ff == S_TRIG1 || state_ff == S_TRIG2);
   assign cor_angle = (state_ff == S_TRIG1) ? {head_ff, 16'd0} : {1'b0, head_ff, 15'd0};

   always_comb begin
      case (step_ff)
         3'd0: begin mul_a = MUL_A_W'(cos_ff); mul_b = MUL_B_W'(vx_ff); end
         3'd1: begin mul_a = MUL_A_W'(sin_ff); mul_b = MUL_B_W'(vy_ff); end
         3'd2: begin mul_a = MUL_A_W'(sin_ff); mul_b = MUL_B_W'(vx_ff); end
         3'd3: begin mul_a = MUL_A_W'(cos_ff); mul_b = MUL_B_W'(vy_ff); end
         3'd4: begin mul_a = accx_ff[MUL_A_W-1:0]; mul_b = signed'({5'd0, dt_ff}); end
         3'd5: begin mul_a = accy_ff[MUL_A_W-1:0]; mul_b = signed'({5'd0, dt_ff}); end
         default: begin mul_a = MUL_A_W'(yaw_ff); mul_b = signed'({5'd0, dt_ff}); end
      endcase
      case (step_ff)
         3'd0: begin div_num = accx_ff; div_den = STEP_DIV; end
         3'd1: begin div_num = accy_ff; div_den = STEP_DIV; end
         default: begin div_num = acch_ff; div_den = US_PER_S; end
      endcase
   end

   assign sum_x = 34'(x_ff) + accx_ff[33:0];
   assign sum_y = 34'(y_ff) + accy_ff[33:0];
   assign sat_x = (sum_x > 34'sd2147483647) || (sum_x < -34'sd2147483648);
   assign sat_y = (sum_y > 34'sd2147483647) || (sum_y < -34'sd2147483648);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      go_in = 1'b0;
      max_dt_in = max_dt_ff;
      dt_in = dt_ff;
      x_in = x_ff;
      y_in = y_ff;
      head_in = head_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      yaw_in = yaw_ff;
      status_in = status_ff;
      sin_in = sin_ff;
      cos_in = cos_ff;
      accx_in = accx_ff;
      accy_in = accy_ff;
      acch_in = acch_ff;
      qz_in = qz_ff;
      qw_in = qw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (csr_valid && csr_ready) begin
         max_dt_in = csr_data[19:0];
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_SET_VEL: begin
                     vx_in = req_tdata[23:0];
                     vy_in = req_tdata[47:24];
                     yaw_in = req_tdata[71:48];
                  end
                  OP_SET_POSE: begin
                     x_in = req_tdata[123:92];
                     y_in = req_tdata[155:124];
                     head_in = req_tdata[171:156];
                  end
                  OP_TICK: begin
                     dt_in = req_dt;
                     go_in = 1'b1;
                     if (req_dt == '0 || req_dt > max_dt_ff) begin
                        status_in = ST_SKIP;
                        state_in = S_TRIG2;
                     end else begin
                        state_in = S_TRIG1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TRIG1: begin
            if (cor_ctl.done) begin
               sin_in = cor_sin;
               cos_in = cor_cos;
               step_in = 3'd0;
               go_in = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_ctl.done) begin
               go_in = 1'b1;
               step_in = step_ff + 1'b1;
               case (step_ff)
                  3'd0: accx_in = mul_p;
                  3'd1: accx_in = accx_ff - mul_p;
                  3'd2: accy_in = mul_p;
                  3'd3: begin
                     accy_in = accy_ff + mul_p;
                     go_in = 1'b0;
                     state_in = S_ROUND;
                  end
                  3'd4: accx_in = mul_p;
                  3'd5: accy_in = mul_p;
                  default: begin
                     acch_in = mul_p;
                     step_in = 3'd0;
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_ROUND: begin
            accx_in = round16(accx_ff);
            accy_in = round16(accy_ff);
            go_in = 1'b1;
            state_in = S_MUL;
         end
         S_DIV: begin
            if (div_ctl.done) begin
               step_in = step_ff + 1'b1;
               case (step_ff)
                  3'd0: begin accx_in = div_q; go_in = 1'b1; end
                  3'd1: begin accy_in = div_q; go_in = 1'b1; end
                  default: begin
                     acch_in = div_q;
                     state_in = S_UPD;
                  end
               endcase
            end
         end
         S_UPD: begin
            x_in = sat_x ? (sum_x[33] ? 32'sh80000000 : 32'sh7fffffff) : sum_x[31:0];
            y_in = sat_y ? (sum_y[33] ? 32'sh80000000 : 32'sh7fffffff) : sum_y[31:0];
            head_in = head_ff + acch_ff[15:0];
            status_in = (sat_x || sat_y) ? ST_SAT : ST_OK;
            go_in = 1'b1;
            state_in = S_TRIG2;
         end
         S_TRIG2: begin
            if (cor_ctl.done) begin
               qz_in = to_q15(cor_sin);
               qw_in = to_q15(cor_cos);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {yaw_ff, vy_ff, vx_ff, qw_ff, qz_ff, head_ff, y_ff, x_ff};
               rsp_user_in = status_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         go_ff <= 1'b0;
         max_dt_ff <= MAX_DT_RESET;
         x_ff <= '0;
         y_ff <= '0;
         head_ff <= '0;
         vx_ff <= '0;
         vy_ff <= '0;
         yaw_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         go_ff <= go_in;
         max_dt_ff <= max_dt_in;
         x_ff <= x_in;
         y_ff <= y_in;
         head_ff <= head_in;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         yaw_ff <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dt_ff <= dt_in;
      status_ff <= status_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
      accx_ff <= accx_in;
      accy_ff <= accy_in;
      acch_ff <= acch_in;
      qz_ff <= qz_in;
      qw_ff <= qw_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   ppi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_ctl.start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_ctl.done),
      .p     (mul_p)
   );

   ppi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_ctl.start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_ctl.done),
      .q     (div_q)
   );

   ppi_cordic #(
      .ITER (TRIG_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_ctl.start),
      .angle   (cor_angle),
      .done    (cor_ctl.done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_ctl.start, div_ctl.start, cor_ctl.start}))
      else $error("more than one arithmetic unit started together");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_ctl.done |-> state_ff == S_MUL)
      else $error("multiplier finished outside the multiply phase");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide phase");

   a_skip: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_TICK && req_dt == '0)
      |=> (state_ff == S_TRIG2 && status_ff == ST_SKIP))
      else $error("zero-length tick was not skipped");

endmodule
